>>> hdl/kpi_pkg.sv
package kpi_pkg;

	localparam int TABLE_SLOTS_DEF = 4096;
	localparam int MAX_DUPS_DEF    = 64;

	localparam int KEY_LO_W = 64;
	localparam int KEY_HI_W = 36;
	localparam int KEY_W    = KEY_LO_W + KEY_HI_W;
	localparam int LINE_W   = 24;
	localparam int START_W  = 8;
	localparam int STATUS_W = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO_VALUE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

	// One classified request as it waits between the front and the back.
	typedef struct packed {
		logic                op;
		logic [KEY_HI_W-1:0] key_hi;
		logic [KEY_LO_W-1:0] key_lo;
		logic [LINE_W-1:0]   line;
		logic [START_W-1:0]  start;
		logic                zero;
	} item_t;

	// One table slot.
	typedef struct packed {
		logic                valid;
		logic [KEY_HI_W-1:0] key_hi;
		logic [KEY_LO_W-1:0] key_lo;
		logic [LINE_W-1:0]   line;
		logic [START_W-1:0]  start;
	} slot_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_CHK,
		S_FIN
	} state_t;

endpackage

>>> hdl/kpi_front.sv
module kpi_front import kpi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clearing,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [KEY_LO_W-1:0] in_key_lo,
	input  logic [KEY_HI_W-1:0] in_key_hi,
	input  logic [LINE_W-1:0]   in_line,
	input  logic [START_W-1:0]  in_start,
	output logic                q_valid,
	input  logic                q_pop,
	output item_t               q_item
);

	item_t      fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	item_t      cls;

	// A zero line and start together form the rejected packed value.
	always_comb begin
		cls.op     = in_op;
		cls.key_hi = in_key_hi;
		cls.key_lo = in_key_lo;
		cls.line   = in_line;
		cls.start  = in_start;
		cls.zero   = (in_line == '0) && (in_start == '0);
	end

	assign in_ready = (cnt_q != 2'd2) && !clearing;
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hdl/kpi_back.sv
module kpi_back import kpi_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int MAX_DUPS    = MAX_DUPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	output logic                clearing,
	input  logic                q_valid,
	output logic                q_pop,
	input  item_t               q_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [LINE_W-1:0]   out_line,
	output logic [START_W-1:0]  out_start,
	output logic                out_last
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W = $clog2(MAX_DUPS + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [IDX_W-1:0] IDX_SPAN = IDX_W'(TABLE_SLOTS);
	localparam logic [CNT_W-1:0] DUP_LIM  = CNT_W'(MAX_DUPS);

	slot_t mem [TABLE_SLOTS];
	slot_t rd_q;

	state_t              state_q, state_d;
	item_t               req_q, req_d;
	logic [IDX_W-1:0]    pos_q, pos_d;
	logic [IDX_W-1:0]    steps_q, steps_d;
	logic [IDX_W-1:0]    clr_q, clr_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                free_q, free_d;
	logic                held_v_q, held_v_d;
	logic [LINE_W-1:0]   held_line_q, held_line_d;
	logic [START_W-1:0]  held_start_q, held_start_d;

	logic                out_v_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [LINE_W-1:0]   out_line_q;
	logic [START_W-1:0]  out_start_q;
	logic                out_last_q;

	logic                out_free;
	logic                out_load;
	logic [STATUS_W-1:0] ld_status;
	logic [LINE_W-1:0]   ld_line;
	logic [START_W-1:0]  ld_start;
	logic                ld_last;

	logic                we;
	logic [IDX_W-1:0]    waddr;
	slot_t               wdata;
	logic                rd_en;
	logic                match;
	logic [IDX_W-1:0]    fold;
	logic [IDX_W-1:0]    home;

	// Home slot: the key folded by XOR onto the index width.
	always_comb begin
		fold = '0;
		for (int i = 0; i < KEY_LO_W; i++) begin
			fold[i % IDX_W] = fold[i % IDX_W] ^ q_item.key_lo[i];
		end
		for (int i = 0; i < KEY_HI_W; i++) begin
			fold[(i + KEY_LO_W) % IDX_W] = fold[(i + KEY_LO_W) % IDX_W] ^ q_item.key_hi[i];
		end
	end

	// The fold stays below twice the table size, so one subtraction brings it in range.
	assign home     = (fold > IDX_LAST) ? (fold - IDX_SPAN) : fold;
	assign match    = rd_q.valid && (rd_q.key_lo == req_q.key_lo)
	                  && (rd_q.key_hi == req_q.key_hi);
	assign out_free = !out_v_q || out_ready;
	assign clearing = (state_q == S_CLEAR);

	always_comb begin
		state_d      = state_q;
		req_d        = req_q;
		pos_d        = pos_q;
		steps_d      = steps_q;
		clr_d        = clr_q;
		count_d      = count_q;
		free_d       = free_q;
		held_v_d     = held_v_q;
		held_line_d  = held_line_q;
		held_start_d = held_start_q;
		q_pop        = 1'b0;
		out_load     = 1'b0;
		ld_status    = ST_OK;
		ld_line      = '0;
		ld_start     = '0;
		ld_last      = 1'b0;
		we           = 1'b0;
		waddr        = pos_q;
		wdata        = '0;
		rd_en        = 1'b0;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == IDX_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					req_d    = q_item;
					pos_d    = home;
					steps_d  = '0;
					count_d  = '0;
					free_d   = 1'b0;
					held_v_d = 1'b0;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (!rd_q.valid) begin
					free_d  = 1'b1;
					state_d = S_FIN;
				end else if (!(match && req_q.op == OP_LOOKUP && held_v_q && !out_free)) begin
					if (match) begin
						count_d = count_q + 1'b1;
						if (req_q.op == OP_LOOKUP) begin
							// The previous match is not the last one: send it on.
							if (held_v_q) begin
								out_load = 1'b1;
								ld_line  = held_line_q;
								ld_start = held_start_q;
							end
							held_v_d     = 1'b1;
							held_line_d  = rd_q.line;
							held_start_d = rd_q.start;
						end
					end
					if (steps_q == IDX_LAST) begin
						state_d = S_FIN;
					end else begin
						pos_d   = (pos_q == IDX_LAST) ? '0 : (pos_q + 1'b1);
						steps_d = steps_q + 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_last  = 1'b1;
					state_d  = S_IDLE;
					if (req_q.op == OP_INSERT) begin
						if (count_q >= DUP_LIM) begin
							ld_status = ST_TOO_MANY;
						end else if (req_q.zero) begin
							ld_status = ST_ZERO_VALUE;
						end else if (!free_q) begin
							ld_status = ST_FULL;
						end else begin
							we           = 1'b1;
							wdata.valid  = 1'b1;
							wdata.key_hi = req_q.key_hi;
							wdata.key_lo = req_q.key_lo;
							wdata.line   = req_q.line;
							wdata.start  = req_q.start;
						end
					end else if (held_v_q) begin
						ld_line  = held_line_q;
						ld_start = held_start_q;
					end else begin
						ld_status = ST_NOT_FOUND;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		req_q        <= req_d;
		pos_q        <= pos_d;
		steps_q      <= steps_d;
		count_q      <= count_d;
		free_q       <= free_d;
		held_line_q  <= held_line_d;
		held_start_q <= held_start_d;
		if (out_load) begin
			out_status_q <= ld_status;
			out_line_q   <= ld_line;
			out_start_q  <= ld_start;
			out_last_q   <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			held_v_q <= held_v_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign out_status = out_status_q;
	assign out_line   = out_line_q;
	assign out_start  = out_start_q;
	assign out_last   = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (count_q <= DUP_LIM))
		else $error("duplicate count beyond limit");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK && state_d == S_CHK) |-> (out_v_q && !out_ready))
		else $error("walk stalled with output free");

	a_last_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ld_last) |-> (state_q == S_FIN))
		else $error("final item loaded outside finish");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output overwritten");

endmodule

>>> hdl/kmer_position_index_top.sv
// Index of 50-base keys to (line, start) pairs with duplicate keys allowed.
// Slave channel: tuser carries the opcode (0 insert, 1 lookup), tdata the
// key, line number and start position. Master channel: one item per insert
// (status, tlast high), one per stored entry on a lookup hit in insertion
// order with tlast on the final one, or one not-found item on a miss.
// Items pass a two-entry queue into a table walker. The walker probes slots
// linearly from a hashed home slot through one single-port memory, reading
// each slot in S_RD and checking it in S_CHK, and a lookup with many
// matches also waits on the receiver. After reset the walker clears every
// slot, and s_tready stays low until that pass ends. When the receiver
// stalls, the held result stays in the output register, the walker halts at
// its next result, and the queue keeps taking items until it is full.
module kmer_position_index_top import kpi_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int MAX_DUPS    = MAX_DUPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // key_low, key_high, line_number, start_position
	input  logic [0:0]   s_tuser,  // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // found_line, found_start
	output logic [2:0]   m_tuser,  // status
	output logic         m_tlast
);

	logic  clearing;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	kpi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[0]),
		.in_key_lo (s_tdata[63:0]),
		.in_key_hi (s_tdata[99:64]),
		.in_line   (s_tdata[123:100]),
		.in_start  (s_tdata[131:124]),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	kpi_back #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.MAX_DUPS    (MAX_DUPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_line   (m_tdata[23:0]),
		.out_start  (m_tdata[31:24]),
		.out_last   (m_tlast)
	);

endmodule
